@@ hw/rtl/wlc_pkg.sv @@
package wlc_pkg;

    // image size defaults
    localparam int IMG_ROWS_DEF = 1024;
    localparam int IMG_COLS_DEF = 1024;

    // field widths
    localparam int ROW_W   = 10;
    localparam int COL_W   = 10;
    localparam int LABEL_W = 16;
    localparam int CNT_W   = 21;
    localparam int SUM_W   = 32;
    localparam int CFG_W   = 12;
    localparam int SPAN_W  = 15;
    localparam int WDATA_W = 16;
    localparam int ADDR_W  = 3;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    // one quotient bit per divider step, means fit in COL_W bits
    localparam int DIV_STEPS = COL_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0] HIT_MAX = {CNT_W{1'b1}};

    // configuration register indexes
    localparam logic [ADDR_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [ADDR_W-1:0] CFG_TARGET = 3'd1;
    localparam logic [ADDR_W-1:0] CFG_TOP    = 3'd2;
    localparam logic [ADDR_W-1:0] CFG_BOTTOM = 3'd3;
    localparam logic [ADDR_W-1:0] CFG_START  = 3'd4;
    localparam logic [ADDR_W-1:0] CFG_RIGHT  = 3'd5;
    localparam logic [ADDR_W-1:0] CFG_WEST   = 3'd6;
    localparam logic [ADDR_W-1:0] CFG_EAST   = 3'd7;

    localparam logic MODE_RECT    = 1'b0;
    localparam logic MODE_DIAMOND = 1'b1;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH,
        ST_DIV,
        ST_WAIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

@@ hw/rtl/wlc_ctrl.sv @@
module wlc_ctrl
    import wlc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_last,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state             r_state, n_state;
    logic [DCNT_W-1:0]  r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_RUN: begin
                if (i_in_valid && i_in_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_state = ST_DIV;
                n_cnt   = DCNT_W'(DIV_STEPS - 1);
            end
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_WAIT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_WAIT: begin
                if (i_sts.out_free) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.div_step = 1'b0;
        o_cmd.out_load = 1'b0;
        case (r_state)
            ST_RUN: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_DIV:  o_cmd.div_step = 1'b1;
            ST_WAIT: o_cmd.out_load = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

@@ hw/rtl/wlc_datapath.sv @@
module wlc_datapath
    import wlc_pkg::*;
#(
    parameter int IMG_ROWS = IMG_ROWS_DEF,
    parameter int IMG_COLS = IMG_COLS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [ADDR_W-1:0]     i_cfg_addr,
    input  logic [WDATA_W-1:0]    i_cfg_wdata,
    input  logic [ROW_W-1:0]      i_pixel_row,
    input  logic [COL_W-1:0]      i_pixel_col,
    input  logic [LABEL_W-1:0]    i_pixel_label,
    input  logic                  i_frame_last,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COL_W-1:0]      o_mean_col,
    output logic [ROW_W-1:0]      o_mean_row,
    output logic [CNT_W-1:0]      o_match_count,
    output logic                  o_window_empty
);

    typedef logic signed [SPAN_W-1:0] t_span;

    localparam t_span ROWS_S  = SPAN_W'(IMG_ROWS);
    localparam t_span COLS_S  = SPAN_W'(IMG_COLS);
    localparam t_span COL_MAX = SPAN_W'(IMG_COLS - 1);
    localparam t_span ONE_S   = SPAN_W'(1);
    localparam int    DSH_W   = CNT_W + DIV_STEPS;

    // configuration
    logic                    r_mode;
    logic [LABEL_W-1:0]      r_target;
    logic signed [CFG_W-1:0] r_top, r_bottom, r_start, r_right, r_west, r_east;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_RECT;
            r_target <= '0;
            r_top    <= '0;
            r_bottom <= '0;
            r_start  <= '0;
            r_right  <= '0;
            r_west   <= '0;
            r_east   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MODE:   r_mode   <= i_cfg_wdata[0];
                CFG_TARGET: r_target <= i_cfg_wdata[LABEL_W-1:0];
                CFG_TOP:    r_top    <= i_cfg_wdata[CFG_W-1:0];
                CFG_BOTTOM: r_bottom <= i_cfg_wdata[CFG_W-1:0];
                CFG_START:  r_start  <= i_cfg_wdata[CFG_W-1:0];
                CFG_RIGHT:  r_right  <= i_cfg_wdata[CFG_W-1:0];
                CFG_WEST:   r_west   <= i_cfg_wdata[CFG_W-1:0];
                CFG_EAST:   r_east   <= i_cfg_wdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    t_span top_s, bottom_s, start_s, right_s, west_s, east_s;
    assign top_s    = SPAN_W'(r_top);
    assign bottom_s = SPAN_W'(r_bottom);
    assign start_s  = SPAN_W'(r_start);
    assign right_s  = SPAN_W'(r_right);
    assign west_s   = SPAN_W'(r_west);
    assign east_s   = SPAN_W'(r_east);

    // span at frame start, rows above the image already walked
    t_span init_n, last_w, last_e, init_a, init_b, init_l, init_r;
    always_comb begin
        init_n = -top_s;
        last_w = (west_s < -ONE_S) ? west_s : -ONE_S;
        last_e = (east_s < -ONE_S) ? east_s : -ONE_S;
        init_a = last_w - top_s + ONE_S;
        init_b = last_e - top_s + ONE_S;
        if (init_a < 0)      init_a = '0;
        if (init_a > init_n) init_a = init_n;
        if (init_b < 0)      init_b = '0;
        if (init_b > init_n) init_b = init_n;
        if (top_s >= 0) begin
            init_l = start_s;
            init_r = start_s;
        end else begin
            init_l = start_s + init_n - init_a - init_a;
            init_r = start_s - init_n + init_b + init_b;
        end
    end

    // stage A: span tracking and window test
    logic             r_frame_start;
    logic [ROW_W-1:0] r_cur_row;
    t_span            r_span_l, r_span_r;

    logic [ROW_W-1:0] cur0;
    t_span            cur_s, row_s, col_s, sl0, sr0, sl1, sr1, n_span_l, n_span_r;
    t_span            lo, hi;
    logic             in_win, hit;

    always_comb begin
        sl0   = r_frame_start ? init_l : r_span_l;
        sr0   = r_frame_start ? init_r : r_span_r;
        cur0  = r_frame_start ? '0 : r_cur_row;
        cur_s = SPAN_W'(cur0);
        row_s = SPAN_W'(i_pixel_row);
        col_s = SPAN_W'(i_pixel_col);
        sl1   = sl0;
        sr1   = sr0;
        if (cur_s < ROWS_S) begin
            if (sl1 < 0)       sl1 = '0;
            if (sr1 > COL_MAX) sr1 = COL_MAX;
        end
        sl1 = (cur_s <= west_s) ? sl1 - ONE_S : sl1 + ONE_S;
        sr1 = (cur_s <= east_s) ? sr1 + ONE_S : sr1 - ONE_S;
        if ((i_pixel_row != cur0) && (cur_s >= top_s)) begin
            n_span_l = sl1;
            n_span_r = sr1;
        end else begin
            n_span_l = sl0;
            n_span_r = sr0;
        end
        lo = (n_span_l < 0) ? '0 : n_span_l;
        hi = (n_span_r > COL_MAX) ? COL_MAX : n_span_r;
        in_win = (row_s >= top_s) && (row_s <= bottom_s) && (row_s < ROWS_S)
                 && (col_s < COLS_S);
        if (r_mode == MODE_RECT) begin
            in_win = in_win && (col_s >= start_s) && (col_s <= right_s);
        end else begin
            in_win = in_win && (col_s >= lo) && (col_s <= hi);
        end
        hit = in_win && (i_pixel_label == r_target);
    end

    logic             r_p_valid, r_p_hit, r_p_last;
    logic [ROW_W-1:0] r_p_row;
    logic [COL_W-1:0] r_p_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_start <= 1'b1;
            r_cur_row     <= '0;
            r_span_l      <= '0;
            r_span_r      <= '0;
            r_p_valid     <= 1'b0;
        end else begin
            r_p_valid <= i_cmd.accept;
            if (i_cmd.accept) begin
                r_frame_start <= i_frame_last;
                r_cur_row     <= i_pixel_row;
                r_span_l      <= n_span_l;
                r_span_r      <= n_span_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_p_hit  <= hit;
            r_p_last <= i_frame_last;
            r_p_row  <= i_pixel_row;
            r_p_col  <= i_pixel_col;
        end
    end

    // stage B: accumulation
    logic [SUM_W-1:0] r_sum_c, r_sum_r, n_sum_c, n_sum_r;
    logic [CNT_W-1:0] r_hits, n_hits;
    logic             take;

    always_comb begin
        take    = r_p_hit && (r_hits != HIT_MAX);
        n_sum_c = r_sum_c + (take ? SUM_W'(r_p_col) : '0);
        n_sum_r = r_sum_r + (take ? SUM_W'(r_p_row) : '0);
        n_hits  = r_hits + CNT_W'(take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_c <= '0;
            r_sum_r <= '0;
            r_hits  <= '0;
        end else if (r_p_valid) begin
            if (r_p_last) begin
                r_sum_c <= '0;
                r_sum_r <= '0;
                r_hits  <= '0;
            end else begin
                r_sum_c <= n_sum_c;
                r_sum_r <= n_sum_r;
                r_hits  <= n_hits;
            end
        end
    end

    // restoring divider, both quotients share the shifted divisor
    logic [SUM_W-1:0] r_rem_c, r_rem_r;
    logic [DSH_W-1:0] r_dsh;
    logic [COL_W-1:0] r_q_c;
    logic [ROW_W-1:0] r_q_r;
    logic [CNT_W-1:0] r_cnt;
    logic             r_empty;
    logic             ge_c, ge_r;

    assign ge_c = SUM_W'(r_dsh) <= r_rem_c;
    assign ge_r = SUM_W'(r_dsh) <= r_rem_r;

    always_ff @(posedge i_clk) begin
        if (r_p_valid && r_p_last) begin
            r_rem_c <= n_sum_c;
            r_rem_r <= n_sum_r;
            r_dsh   <= {n_hits, {(DIV_STEPS - 1){1'b0}}, 1'b0} >> 1;
            r_cnt   <= n_hits;
            r_empty <= (n_hits == '0);
        end else if (i_cmd.div_step) begin
            if (ge_c) r_rem_c <= r_rem_c - SUM_W'(r_dsh);
            if (ge_r) r_rem_r <= r_rem_r - SUM_W'(r_dsh);
            r_q_c <= {r_q_c[COL_W-2:0], ge_c};
            r_q_r <= {r_q_r[ROW_W-2:0], ge_r};
            r_dsh <= r_dsh >> 1;
        end
    end

    // output register
    logic r_out_valid;

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_mean_col     <= r_empty ? '0 : r_q_c;
            o_mean_row     <= r_empty ? '0 : r_q_r;
            o_match_count  <= r_cnt;
            o_window_empty <= r_empty;
        end
    end

endmodule

@@ hw/rtl/window_label_centroid.sv @@
// centroid of one label inside a rectangle or diamond window of a label image
//
// input channel s_axis: one pixel per item in raster order, row and column and
// label in tdata, tlast on the final pixel of the frame. pixels are taken one
// per clock while the block is collecting.
// output channel m_axis: one item per frame, truncated mean column and row and
// the match count in tdata, the empty flag in tuser.
// configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_addr; write
// only while no frame is in progress.
//
// once the tlast pixel is accepted, the sums are closed, the shared bit-serial
// divider runs (one quotient bit per cycle for both means) and the result is
// loaded into the output register. s_axis_tready is low from the tlast pixel
// until that load. the next frame is accepted while the result waits in the
// output register; if the receiver still stalls when the following frame ends,
// the divider holds its answer and tready stays low until the output frees up.
// reset (synchronous, active low) clears sums, config and the output valid and
// arms the frame-start load of the diamond span.
module window_label_centroid
    import wlc_pkg::*;
#(
    parameter int IMG_ROWS = IMG_ROWS_DEF,
    parameter int IMG_COLS = IMG_COLS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [ADDR_W-1:0]     i_cfg_addr,
    input  logic [WDATA_W-1:0]    i_cfg_wdata,
    // pixel items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // pixel_row, pixel_col, pixel_label, pad
    input  logic                  s_axis_tlast,  // frame_last
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // mean_col, mean_row, match_count, pad
    output logic                  m_axis_tuser   // window_empty
);

    t_cmd             cmd;
    t_sts             sts;
    logic [COL_W-1:0] mean_col;
    logic [ROW_W-1:0] mean_row;
    logic [CNT_W-1:0] match_count;

    // sequencing: collect, close sums, divide, hand off
    wlc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // window tracking, accumulators, divider and output register
    wlc_datapath #(
        .IMG_ROWS (IMG_ROWS),
        .IMG_COLS (IMG_COLS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_pixel_row    (s_axis_tdata[ROW_W-1:0]),
        .i_pixel_col    (s_axis_tdata[ROW_W+COL_W-1:ROW_W]),
        .i_pixel_label  (s_axis_tdata[ROW_W+COL_W+LABEL_W-1:ROW_W+COL_W]),
        .i_frame_last   (s_axis_tlast),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_mean_col     (mean_col),
        .o_mean_row     (mean_row),
        .o_match_count  (match_count),
        .o_window_empty (m_axis_tuser)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - COL_W - ROW_W - CNT_W){1'b0}},
                           match_count, mean_row, mean_col};

`ifndef ASSERT_OFF
    // the frame's final pixel closes the input until the result is handed off
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input still open after frame end");

    // an empty window reports zero means
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[COL_W+ROW_W-1:0] == '0))
        else $error("empty window with nonzero means");

    // a non-empty result carries a nonzero count
    a_count_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |->
            (m_axis_tdata[COL_W+ROW_W+CNT_W-1:COL_W+ROW_W] != '0))
        else $error("zero count without empty flag");
`endif

endmodule
